// ----- hdl/iic_pkg.sv -----
// ----------------------------------------------------------------------------
// Integral image package
// Shared widths, register indexes, command and status types, and helpers.
// ----------------------------------------------------------------------------
package iic_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned AccW      = 32;
  localparam int unsigned SumW      = 42;
  localparam int unsigned ValW      = 52;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned HeightW   = 11;
  localparam int unsigned PowerW    = 3;
  localparam int unsigned CntW      = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_POWER  = 1'b1;

  localparam logic [HeightW-1:0] HeightReset = HeightW'(MaxHeight);
  localparam logic [PowerW-1:0]  PowerReset  = PowerW'(1);

  typedef struct packed {
    logic load;
    logic rd_en;
    logic step;
    logic add;
    logic finish;
  } iic_cmd_t;

  typedef struct packed {
    logic pow_done;
  } iic_sts_t;

  // Number of extra multiplications for a power code; 0 acts as 1, above 4 as 4.
  function automatic logic [CntW-1:0] extra_mults(input logic [PowerW-1:0] p);
    logic [CntW-1:0] r;
    if (p <= PowerW'(1)) begin
      r = '0;
    end else if (p >= PowerW'(4)) begin
      r = CntW'(3);
    end else begin
      r = CntW'(p - PowerW'(1));
    end
    return r;
  endfunction

  // Index of the last row of a column for a height code, clamped to 1..MaxHeight.
  function automatic logic [RowW-1:0] last_row(input logic [HeightW-1:0] h);
    logic [RowW-1:0] r;
    if (h == '0) begin
      r = '0;
    end else if (h > HeightW'(MaxHeight)) begin
      r = RowW'(MaxHeight - 1);
    end else begin
      r = RowW'(h - HeightW'(1));
    end
    return r;
  endfunction

endpackage

// ----- hdl/integral_image_column_order.sv -----
// ----------------------------------------------------------------------------
// Integral image, column order
// Summed-area table over 8-bit pixels that arrive column by column.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (pixel_i, frame_start_i) with a
// valid/ready handshake, column by column and top to bottom. Each request
// yields one result on the output channel: the summed-area value of that
// position and a flag that marks the last row of a column.
// After acceptance a request passes through a RAM read, the power step,
// the column sum and the result; the power step multiplies on the 24 by
// 8 bit multiplier of the power unit once for each extra multiplication.
// The block takes no new request until the previous one has finished
// and the controller is back in idle.
// The previous column lives in a 1024 by 52 bit RAM, read once and
// written once per request at the current row.
// The output register holds a result until it is taken; a stalled
// receiver holds the next request in its final cycle, and the input
// channel keeps ready low until that result has moved out.
// Reset puts the height to 1024 rows and the power to 1 and starts a new
// image; the RAM is not cleared. Configuration writes are taken at any
// time but must only be made while the block is idle.
// ----------------------------------------------------------------------------
module integral_image_column_order (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iic_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iic_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [iic_pkg::PixW-1:0]      pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iic_pkg::ValW-1:0]      integral_value_o,
  output logic                          column_end_o
);

  iic_pkg::iic_cmd_t cmd;
  iic_pkg::iic_sts_t sts;

  iic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iic_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_i          (pixel_i),
    .frame_start_i    (frame_start_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .integral_value_o (integral_value_o),
    .column_end_o     (column_end_o)
  );

endmodule

// ----- hdl/iic_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module iic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/iic_datapath.sv -----
// ----------------------------------------------------------------------------
// Integral image datapath
// Configuration registers, pixel power unit, column sum, row store, result.
// ----------------------------------------------------------------------------
module iic_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iic_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iic_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [iic_pkg::PixW-1:0]      pixel_i,
  input  logic                          frame_start_i,
  input  iic_pkg::iic_cmd_t             cmd_i,
  output iic_pkg::iic_sts_t             sts_o,
  output logic [iic_pkg::ValW-1:0]      integral_value_o,
  output logic                          column_end_o
);

  logic [iic_pkg::HeightW-1:0] height_q;
  logic [iic_pkg::PowerW-1:0]  power_q;
  logic [iic_pkg::PixW-1:0]    pix_q;
  logic [iic_pkg::AccW-1:0]    acc_q, acc_d;
  logic [iic_pkg::CntW-1:0]    cnt_q;
  logic [iic_pkg::SumW-1:0]    col_sum_q;
  logic [iic_pkg::RowW-1:0]    row_q;
  logic                        first_q;
  logic [iic_pkg::ValW-1:0]    val_q, val_d;
  logic                        end_q, end_d;
  logic [iic_pkg::ValW-1:0]    prev_data;
  logic [iic_pkg::ValW-1:0]    prev_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= iic_pkg::HeightReset;
      power_q  <= iic_pkg::PowerReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iic_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[iic_pkg::HeightW-1:0];
        iic_pkg::CFG_PIXEL_POWER:  power_q  <= cfg_data_i[iic_pkg::PowerW-1:0];
        default: ;
      endcase
    end
  end

  assign acc_d = {{(iic_pkg::AccW-24){1'b0}}, acc_q[23:0]}
               * {{(iic_pkg::AccW-iic_pkg::PixW){1'b0}}, pix_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pixel_i;
      acc_q <= {{(iic_pkg::AccW-iic_pkg::PixW){1'b0}}, pixel_i};
      cnt_q <= iic_pkg::extra_mults(power_q);
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      cnt_q <= cnt_q - iic_pkg::CntW'(1);
    end
  end

  assign sts_o.pow_done = (cnt_q == '0);

  assign prev_term = first_q ? '0 : prev_data;
  assign val_d     = {{(iic_pkg::ValW-iic_pkg::SumW){1'b0}}, col_sum_q} + prev_term;
  assign end_d     = (row_q >= iic_pkg::last_row(height_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q <= '0;
      row_q     <= '0;
      first_q   <= 1'b1;
    end else if (cmd_i.load) begin
      if (frame_start_i) begin
        col_sum_q <= '0;
        row_q     <= '0;
        first_q   <= 1'b1;
      end
    end else if (cmd_i.add) begin
      col_sum_q <= col_sum_q + {{(iic_pkg::SumW-iic_pkg::AccW){1'b0}}, acc_q};
    end else if (cmd_i.finish) begin
      if (end_d) begin
        col_sum_q <= '0;
        row_q     <= '0;
        first_q   <= 1'b0;
      end else begin
        row_q <= row_q + iic_pkg::RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      val_q <= val_d;
      end_q <= end_d;
    end
  end

  iic_ram #(
    .Width (iic_pkg::ValW),
    .Depth (iic_pkg::MaxHeight)
  ) u_prev_col (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish),
    .waddr_i (row_q),
    .wdata_i (val_d),
    .re_i    (cmd_i.rd_en),
    .raddr_i (row_q),
    .rdata_o (prev_data)
  );

  assign integral_value_o = val_q;
  assign column_end_o     = end_q;

endmodule

// ----- hdl/iic_ctrl.sv -----
// ----------------------------------------------------------------------------
// Integral image controller
// Sequences one request through read, power, sum and result, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module iic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  iic_pkg::iic_sts_t sts_i,
  output iic_pkg::iic_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_POW  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_POW;
      end
      S_POW: begin
        if (sts_i.pow_done) begin
          state_d = S_ADD;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RD))
    else $error("accepted request did not start a read");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished request");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("request finished over a result not yet taken");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.rd_en, cmd_o.step, cmd_o.add, cmd_o.finish}))
    else $error("more than one datapath command at once");

endmodule
